### rtl/cdrom_command_controller_core_defines.svh
// ----------------------------------------------------------------------------
// Disc controller assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef CDROM_COMMAND_CONTROLLER_CORE_DEFINES_SVH
`define CDROM_COMMAND_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define CCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define CCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// Disc controller package
// Word types, codes and small helper functions.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int unsigned PARAM_DEPTH_DEF    = 16;
	localparam int unsigned RESPONSE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_EVENT = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic [1:0] PORT_0 = 2'd0;
	localparam logic [1:0] PORT_1 = 2'd1;
	localparam logic [1:0] PORT_2 = 2'd2;
	localparam logic [1:0] PORT_3 = 2'd3;

	localparam logic [2:0] CAUSE_NONE = 3'd0;
	localparam logic [2:0] CAUSE_ACK  = 3'd3;
	localparam logic [2:0] CAUSE_DONE = 3'd2;
	localparam logic [2:0] CAUSE_ERR  = 3'd5;

	localparam logic [7:0] CMD_NOP    = 8'd1;
	localparam logic [7:0] CMD_SETLOC = 8'd2;
	localparam logic [7:0] CMD_INIT   = 8'd10;
	localparam logic [7:0] CMD_GETTN  = 8'd19;
	localparam logic [7:0] CMD_LAST   = 8'd30;

	localparam logic [16:0] DLY_ACK   = 17'd350;
	localparam logic [16:0] DLY_SHORT = 17'd750;
	localparam logic [16:0] DLY_SEEK  = 17'd1000;
	localparam logic [16:0] DLY_LONG  = 17'd2000;
	localparam logic [16:0] DLY_INIT  = 17'd120000;

	localparam logic [7:0] ERR_ARGS  = 8'h20;
	localparam logic [7:0] ERR_CMD   = 8'h40;
	localparam logic [7:0] ERR_SEEK  = 8'h10;
	localparam logic [7:0] CAUSE_OR  = 8'he0;
	localparam logic [7:0] ACK_A     = 8'h07;
	localparam logic [7:0] ACK_B     = 8'h1f;

	localparam logic [1:0] REG_TRACK_COUNT = 2'd0;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] port;
		logic [7:0] write_data;
		logic       lid_open;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        irq_pulse;
		logic [16:0] event_delay_us;
		logic        unsupported_access;
	} out_word_t;

	typedef struct packed {
		logic       fixed;
		logic [1:0] count;
	} arg_info_t;

	function automatic arg_info_t arg_info(input logic [4:0] cmd);
		arg_info_t r;
		r = '{fixed: 1'b1, count: 2'd0};
		case (cmd)
			5'd2:  r.count = 2'd3;
			5'd3:  r.fixed = 1'b0;
			5'd13: r.count = 2'd2;
			5'd14: r.count = 2'd1;
			5'd18: r.count = 2'd1;
			5'd20: r.count = 2'd1;
			5'd25: r.fixed = 1'b0;
			default: r.count = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] to_bcd(input logic [6:0] t);
		logic [17:0] p;
		logic [3:0]  tens;
		logic [6:0]  rem;
		p    = 18'(t) * 18'd205;
		tens = p[14:11];
		rem  = t - 7'(tens) * 7'd10;
		return {tens, rem[3:0]};
	endfunction

	function automatic logic bcd_ok(input logic [7:0] v);
		return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
	endfunction

	function automatic logic [6:0] bcd_val(input logic [7:0] v);
		return 7'(v[7:4]) * 7'd10 + 7'(v[3:0]);
	endfunction

endpackage

### rtl/cdrom_command_controller_core.sv
// ----------------------------------------------------------------------------
// Disc controller core
// Four byte ports with bank select, parameter and response FIFOs and
// command stepping driven by scheduled-event words.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready carry one word per bus access or elapsed event;
//  out_valid/out_ready return exactly one result word for each.
//  The word is decoded, the state updated and the result loaded into the
//  output register at the accepting edge.
//  Throughput is one word per cycle: in_ready stays high while the output
//  register is empty or being drained in the same cycle.
//  When the receiver stalls, the result is held and in_ready drops until
//  it is taken.
//  The APB port holds track_count at address 0; writes land when psel,
//  penable and pwrite are high, pready is tied high.
//  Reset clears all control state; track_count returns to 1, no result
//  is pending and in_ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module cdrom_command_controller_core #(
	parameter int unsigned PARAM_DEPTH    = ccc_pkg::PARAM_DEPTH_DEF,
	parameter int unsigned RESPONSE_DEPTH = ccc_pkg::RESPONSE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ccc_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output ccc_pkg::out_word_t out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned PCW = $clog2(PARAM_DEPTH + 1);
	localparam int unsigned RCW = $clog2(RESPONSE_DEPTH + 1);

	logic [6:0]     track_q;
	logic [1:0]     bank_q, bank_d;
	logic [7:0]     par_q [3], par_d [3];
	logic [PCW-1:0] pcnt_q, pcnt_d;
	logic [7:0]     resp_q [3], resp_d [3];
	logic [RCW-1:0] rcnt_q, rcnt_d;
	logic [RCW-1:0] rpos_q, rpos_d;
	logic [2:0]     cause_q, cause_d;
	logic [1:0]     step_q, step_d;
	logic [7:0]     act_q, act_d;
	logic           argerr_q, argerr_d;
	logic           motor_q, motor_d;
	logic           lidw_q, lidw_d;
	logic           ackr_q, ackr_d;
	logic           ackw_q, ackw_d;

	ccc_pkg::out_word_t res;
	logic               accept;
	logic               run;
	logic               lidw;
	logic [7:0]         status;
	logic [7:0]         rbyte;
	ccc_pkg::arg_info_t ai;
	logic               loc_ok;

	assign accept   = in_valid & in_ready;
	assign in_ready = ~out_valid | out_ready;
	assign pready   = 1'b1;
	assign prdata   = {25'd0, track_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == ccc_pkg::REG_TRACK_COUNT) begin
			track_q <= pwdata[6:0];
		end
	end

	always_comb begin
		case (rpos_q[1:0])
			2'd0:    rbyte = resp_q[0];
			2'd1:    rbyte = resp_q[1];
			default: rbyte = resp_q[2];
		endcase
	end

	assign ai     = ccc_pkg::arg_info(in_word.write_data[4:0]);
	assign loc_ok = ccc_pkg::bcd_ok(par_q[0]) && ccc_pkg::bcd_ok(par_q[1])
		&& ccc_pkg::bcd_ok(par_q[2]) && ccc_pkg::bcd_val(par_q[1]) < 7'd60
		&& ccc_pkg::bcd_val(par_q[2]) < 7'd75;
	assign lidw   = lidw_q | in_word.lid_open;
	assign status = {3'd0, lidw, 2'd0, motor_q & ~in_word.lid_open, 1'b0};

	always_comb begin
		bank_d   = bank_q;
		par_d    = par_q;
		pcnt_d   = pcnt_q;
		resp_d   = resp_q;
		rcnt_d   = rcnt_q;
		rpos_d   = rpos_q;
		cause_d  = cause_q;
		step_d   = step_q;
		act_d    = act_q;
		argerr_d = argerr_q;
		motor_d  = motor_q;
		lidw_d   = lidw;
		ackr_d   = ackr_q;
		ackw_d   = ackw_q;
		res      = '0;
		run      = 1'b0;
		case (ccc_pkg::kind_t'(in_word.command))
			ccc_pkg::KIND_READ: begin
				case (in_word.port)
					ccc_pkg::PORT_0: begin
						res.read_data = {6'd0, bank_q};
						if (pcnt_q == '0) res.read_data[3] = 1'b1;
						if (pcnt_q < PCW'(PARAM_DEPTH)) res.read_data[4] = 1'b1;
						if (rpos_q < rcnt_q) res.read_data[5] = 1'b1;
					end
					ccc_pkg::PORT_1: begin
						if (rpos_q < rcnt_q) begin
							res.read_data = rbyte;
							rpos_d = rpos_q + 1'b1;
						end
					end
					ccc_pkg::PORT_3: begin
						if (!bank_q[0]) begin
							res.unsupported_access = 1'b1;
						end else begin
							res.read_data = ccc_pkg::CAUSE_OR | {5'd0, cause_q};
							cause_d = ccc_pkg::CAUSE_NONE;
						end
					end
					default: res.read_data = 8'd0;
				endcase
			end
			ccc_pkg::KIND_WRITE: begin
				case (in_word.port)
					ccc_pkg::PORT_0: bank_d = in_word.write_data[1:0];
					ccc_pkg::PORT_1: begin
						if (bank_q != 2'd0) begin
							res.unsupported_access = 1'b1;
						end else begin
							act_d = in_word.write_data;
							if (in_word.write_data > ccc_pkg::CMD_LAST) begin
								res.unsupported_access = 1'b1;
							end else if (ai.fixed && pcnt_q != PCW'(ai.count)) begin
								argerr_d = 1'b1;
								res.event_delay_us = ccc_pkg::DLY_SHORT;
							end else begin
								run = 1'b1;
							end
						end
					end
					ccc_pkg::PORT_2: begin
						if (bank_q == 2'd0) begin
							if (pcnt_q < PCW'(PARAM_DEPTH)) begin
								if (pcnt_q < PCW'(3)) par_d[pcnt_q[1:0]] = in_word.write_data;
								pcnt_d = pcnt_q + 1'b1;
							end
						end else if (bank_q == 2'd1) begin
							if (in_word.write_data != ccc_pkg::ACK_B) res.unsupported_access = 1'b1;
						end else begin
							res.unsupported_access = 1'b1;
						end
					end
					default: begin
						if (bank_q == 2'd1) begin
							if (in_word.write_data == ccc_pkg::ACK_A
									|| in_word.write_data == ccc_pkg::ACK_B) begin
								if (ackw_q) begin
									ackw_d = 1'b0;
									res.event_delay_us = ccc_pkg::DLY_ACK;
								end
								ackr_d = 1'b1;
							end else if (in_word.write_data[4:3] == 2'd0) begin
								res.unsupported_access = 1'b1;
							end
						end else begin
							res.unsupported_access = 1'b1;
						end
					end
				endcase
			end
			ccc_pkg::KIND_EVENT: begin
				if (argerr_q) begin
					argerr_d  = 1'b0;
					cause_d   = ccc_pkg::CAUSE_ERR;
					pcnt_d    = '0;
					act_d     = 8'd0;
					resp_d[0] = status | 8'd1;
					resp_d[1] = ccc_pkg::ERR_ARGS;
					rcnt_d    = RCW'(2);
					rpos_d    = '0;
					if (!in_word.lid_open) lidw_d = 1'b0;
					ackr_d    = 1'b0;
					res.irq_pulse = 1'b1;
				end else begin
					run = 1'b1;
				end
			end
			default: res = '0;
		endcase

		if (run) begin
			if (act_d == ccc_pkg::CMD_INIT) begin
				if (step_q == 2'd0) begin
					step_d  = 2'd1;
					motor_d = 1'b1;
					res.event_delay_us = ccc_pkg::DLY_LONG;
				end else if (step_q == 2'd1) begin
					cause_d   = ccc_pkg::CAUSE_ACK;
					step_d    = 2'd2;
					resp_d[0] = status;
					rcnt_d    = RCW'(1);
					rpos_d    = '0;
					if (!in_word.lid_open) lidw_d = 1'b0;
					ackr_d    = 1'b0;
					res.irq_pulse      = 1'b1;
					res.event_delay_us = ccc_pkg::DLY_INIT;
				end else if (step_q == 2'd2 && !ackr_q) begin
					ackw_d = 1'b1;
					step_d = 2'd3;
				end else begin
					cause_d   = ccc_pkg::CAUSE_DONE;
					step_d    = 2'd0;
					resp_d[0] = status;
					rcnt_d    = RCW'(1);
					rpos_d    = '0;
					if (!in_word.lid_open) lidw_d = 1'b0;
					act_d     = 8'd0;
					ackr_d    = 1'b0;
					res.irq_pulse = 1'b1;
				end
			end else if (step_q == 2'd0) begin
				step_d = 2'd1;
				if (act_d == ccc_pkg::CMD_SETLOC) res.event_delay_us = ccc_pkg::DLY_SEEK;
				else if (act_d == ccc_pkg::CMD_GETTN) res.event_delay_us = ccc_pkg::DLY_LONG;
				else res.event_delay_us = ccc_pkg::DLY_SHORT;
			end else if (step_q == 2'd1) begin
				rpos_d = '0;
				if (!in_word.lid_open) lidw_d = 1'b0;
				cause_d = ccc_pkg::CAUSE_ACK;
				if (act_d == ccc_pkg::CMD_NOP) begin
					resp_d[0] = status;
					rcnt_d    = RCW'(1);
				end else if (act_d == ccc_pkg::CMD_SETLOC) begin
					if (loc_ok) begin
						resp_d[0] = status;
						rcnt_d    = RCW'(1);
					end else begin
						resp_d[0] = status | 8'd1;
						resp_d[1] = ccc_pkg::ERR_SEEK;
						rcnt_d    = RCW'(2);
						cause_d   = ccc_pkg::CAUSE_ERR;
					end
				end else if (act_d == ccc_pkg::CMD_GETTN) begin
					resp_d[0] = status;
					resp_d[1] = 8'd1;
					resp_d[2] = ccc_pkg::to_bcd(track_q);
					rcnt_d    = RCW'(3);
				end else begin
					resp_d[0] = status | 8'd1;
					resp_d[1] = ccc_pkg::ERR_CMD;
					rcnt_d    = RCW'(2);
					cause_d   = ccc_pkg::CAUSE_ERR;
				end
				pcnt_d = '0;
				step_d = 2'd0;
				act_d  = 8'd0;
				ackr_d = 1'b0;
				res.irq_pulse = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= '0;
			pcnt_q   <= '0;
			rcnt_q   <= '0;
			rpos_q   <= '0;
			cause_q  <= ccc_pkg::CAUSE_NONE;
			step_q   <= '0;
			act_q    <= '0;
			argerr_q <= 1'b0;
			motor_q  <= 1'b0;
			lidw_q   <= 1'b0;
			ackr_q   <= 1'b0;
			ackw_q   <= 1'b0;
		end else if (accept) begin
			bank_q   <= bank_d;
			pcnt_q   <= pcnt_d;
			rcnt_q   <= rcnt_d;
			rpos_q   <= rpos_d;
			cause_q  <= cause_d;
			step_q   <= step_d;
			act_q    <= act_d;
			argerr_q <= argerr_d;
			motor_q  <= motor_d;
			lidw_q   <= lidw_d;
			ackr_q   <= ackr_d;
			ackw_q   <= ackw_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			par_q    <= par_d;
			resp_q   <= resp_d;
			out_word <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

### rtl/ccc_checker.sv
// ----------------------------------------------------------------------------
// Disc controller port checker
// Watches the core's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "cdrom_command_controller_core_defines.svh"

module ccc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ccc_pkg::out_word_t out_word
);

	logic delay_legal;

	assign delay_legal = out_word.event_delay_us == 17'd0
		|| out_word.event_delay_us == ccc_pkg::DLY_ACK
		|| out_word.event_delay_us == ccc_pkg::DLY_SHORT
		|| out_word.event_delay_us == ccc_pkg::DLY_SEEK
		|| out_word.event_delay_us == ccc_pkg::DLY_LONG
		|| out_word.event_delay_us == ccc_pkg::DLY_INIT;

	`CCC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
	`CCC_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(out_word), "result dropped under stall")
	`CCC_ASSERT_NOW(a_irq_no_read, out_valid && out_word.irq_pulse, out_word.read_data == 8'd0, "interrupt on a read word")
	`CCC_ASSERT_NOW(a_delay_legal, out_valid, delay_legal, "unknown event delay")
	`CCC_ASSERT_NEXT(a_word_out, in_valid && in_ready, out_valid, "accepted word gave no result")

endmodule

bind cdrom_command_controller_core ccc_checker u_ccc_checker (.*);
